@@ rtl/core/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the md5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic        last_word;
    logic [2:0]  byte_count;
    logic [31:0] data_word;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } md5_out_t;

  // request from the sequencer to the block memory
  typedef struct packed {
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
  } md5_mem_req_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] PAD_BYTE = 32'h0000_0080;
  localparam logic [3:0]  LEN_LO_IDX = 4'd14;

  function automatic logic [31:0] md5_sine(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_shift(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by round i
  function automatic logic [3:0] md5_word_sel(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] n;
    n = i[3:0];
    case (i[5:4])
      2'd0: g = n;
      2'd1: g = 4'((n << 2) + n + 4'd1);
      2'd2: g = 4'((n << 1) + n + 4'd5);
      default: g = 4'((n << 3) - n);
    endcase
    return g;
  endfunction

endpackage

@@ rtl/core/md5_digest_engine.sv @@
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 digest over a stream of little-endian 32-bit words with padding.
// ----------------------------------------------------------------------------
//  channel | ports                       | payload
//  input   | in_valid in_stall in_item   | data_word byte_count last_word
//  output  | out_valid out_stall out_item| digest_low digest_high
//
// a non-final word is written directly; one that completes a block also starts
// a compression (a read, 64 rounds on the shared round unit, one chaining add)
// the final word writes its padding one word per cycle plus one or two
// compressions; the digest sits in an output register until taken
// reset clears control, chaining words and length; block memory is not cleared
// a stalled digest blocks the next final word only
module md5_digest_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  md5_pkg::md5_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output md5_pkg::md5_out_t out_item
);
  import md5_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_READ, S_RUN, S_ADD} state_t;

  state_t       state_r, state_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [127:0] chain_r, chain_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic         fin_r, fin_nxt;    // final word seen, padding in progress
  logic         hold_r, hold_nxt;  // four-byte final: 0x80 word still to write
  logic         len_blk_r, len_blk_nxt;  // this block takes the length words
  logic         out_valid_r, out_valid_nxt;
  md5_out_t     out_item_r, out_item_nxt;

  md5_mem_req_t req;
  logic [31:0]  rd_data;
  logic [127:0] words;
  logic         accept;
  logic [2:0]   bc;
  logic [31:0]  mask, padw;

  md5_block_ram u_ram (.clk(clk), .req(req), .rd_data(rd_data));

  md5_round u_round (
    .clk(clk), .load(state_r == S_READ), .load_val(chain_r),
    .step(state_r == S_RUN), .rnd(rnd_r), .msg_word(rd_data), .words(words)
  );

  assign in_stall = (state_r != S_IDLE) || (in_item.last_word && out_valid_r);
  assign accept   = in_valid && !in_stall;
  assign bc       = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
  assign mask     = 32'((33'd1 << {bc, 3'b000}) - 33'd1);
  assign padw     = (in_item.data_word & mask) | 32'(PAD_BYTE << {bc, 3'b000});

  // sequencing of writes, padding, compression and digest
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    chain_nxt     = chain_r;
    rnd_nxt       = rnd_r;
    fin_nxt       = fin_r;
    hold_nxt      = hold_r;
    len_blk_nxt   = len_blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    req.wr_en     = 1'b0;
    req.wr_addr   = idx_r;
    req.wr_data   = 32'h0;
    req.rd_addr   = md5_word_sel(rnd_nxt);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req.wr_en = 1'b1;
          idx_nxt   = idx_r + 4'd1;
          if (!in_item.last_word) begin
            req.wr_data = in_item.data_word;
            len_nxt     = len_r + 64'd32;
            if (idx_r == 4'd15) state_nxt = S_READ;
          end else begin
            len_nxt  = len_r + 64'({bc, 3'b000});
            fin_nxt  = 1'b1;
            hold_nxt = (bc == 3'd4);
            // length fits behind the pad byte only up to word 13
            len_blk_nxt = (bc != 3'd4) && (idx_r <= 4'd13);
            req.wr_data = (bc == 3'd4) ? in_item.data_word : padw;
            state_nxt = (idx_r == 4'd15) ? S_READ : S_PAD;
          end
          rnd_nxt     = 6'd0;
          req.rd_addr = 4'd0;
        end
      end
      S_PAD: begin
        req.wr_en = 1'b1;
        idx_nxt   = idx_r + 4'd1;
        if (hold_r) begin
          req.wr_data = PAD_BYTE;
          hold_nxt    = 1'b0;
          len_blk_nxt = (idx_r <= 4'd13);
        end else if (len_blk_r && idx_r == LEN_LO_IDX) begin
          req.wr_data = len_r[31:0];
        end else if (len_blk_r && idx_r == 4'd15) begin
          req.wr_data = len_r[63:32];
        end else begin
          req.wr_data = 32'h0;
        end
        rnd_nxt     = 6'd0;
        req.rd_addr = 4'd0;
        if (idx_r == 4'd15) state_nxt = S_READ;
      end
      S_READ: begin
        rnd_nxt     = 6'd0;
        req.rd_addr = md5_word_sel(6'd0);
        state_nxt   = S_RUN;
      end
      S_RUN: begin
        rnd_nxt     = rnd_r + 6'd1;
        req.rd_addr = md5_word_sel(6'(rnd_r + 6'd1));
        if (rnd_r == 6'd63) state_nxt = S_ADD;
      end
      S_ADD: begin
        for (int k = 0; k < 4; k++) begin
          chain_nxt[k*32 +: 32] = chain_r[k*32 +: 32] + words[k*32 +: 32];
        end
        // padding done when the length words were just compressed
        if (fin_r && len_blk_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = chain_nxt;
          chain_nxt     = {INIT_D, INIT_C, INIT_B, INIT_A};
          len_nxt       = 64'h0;
          fin_nxt       = 1'b0;
          len_blk_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else if (fin_r) begin
          // extra block of padding carries the length
          len_blk_nxt = 1'b1;
          state_nxt   = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 4'd0;
      len_r       <= 64'h0;
      chain_r     <= {INIT_D, INIT_C, INIT_B, INIT_A};
      rnd_r       <= 6'd0;
      fin_r       <= 1'b0;
      hold_r      <= 1'b0;
      len_blk_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      chain_r     <= chain_nxt;
      rnd_r       <= rnd_nxt;
      fin_r       <= fin_nxt;
      hold_r      <= hold_nxt;
      len_blk_r   <= len_blk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> in_stall) else $error("item taken during compression");
  a_round_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && rnd_r != 6'd63) |=> (state_r == S_RUN && rnd_r == $past(rnd_r) + 6'd1))
    else $error("round counter skipped");
  a_digest_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> ($past(state_r) == S_ADD))
    else $error("digest not from chaining add");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (state_r == S_IDLE && idx_r == 4'd0))
    else $error("engine not restarted after digest");

endmodule

@@ rtl/core/md5_block_ram.sv @@
// ----------------------------------------------------------------------------
// md5_block_ram
// Sixteen-word message block store, one write and one registered read port.
// ----------------------------------------------------------------------------
module md5_block_ram (
  input  logic                  clk,
  input  md5_pkg::md5_mem_req_t req,
  output logic [31:0]           rd_data
);
  import md5_pkg::*;

  logic [31:0] mem [16];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

@@ rtl/core/md5_round.sv @@
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round: mixing function, additions and rotation, working words held.
// ----------------------------------------------------------------------------
module md5_round (
  input  logic         clk,
  input  logic         load,
  input  logic [127:0] load_val,
  input  logic         step,
  input  logic [5:0]   rnd,
  input  logic [31:0]  msg_word,
  output logic [127:0] words
);
  import md5_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] f, sum;
  logic [63:0] dbl;
  logic [4:0]  sh;

  // mixing function of the round group
  always_comb begin
    case (rnd[5:4])
      2'd0: f = d_r ^ (b_r & (c_r ^ d_r));
      2'd1: f = c_r ^ (d_r & (b_r ^ c_r));
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum = f + a_r + md5_sine(rnd) + msg_word;
    sh  = md5_shift(rnd);
    dbl = {sum, sum} << sh;
  end

  // working words
  always_ff @(posedge clk) begin
    if (load) begin
      {d_r, c_r, b_r, a_r} <= load_val;
    end else if (step) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + dbl[63:32];
    end
  end

  assign words = {d_r, c_r, b_r, a_r};

endmodule
